FILE: hw/rtl/tkim_pkg.sv
package tkim_pkg;

	localparam int TRIE_NODES = 256;
	localparam int MAX_IDS    = 256;

	localparam int FANOUT_W   = 8;
	localparam int KEY_ID_W   = 8;
	localparam int STATUS_W   = 2;
	localparam int NODE_W     = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
	localparam int ADDR_W     = NODE_W + FANOUT_W;
	localparam int NCNT_W     = $clog2(TRIE_NODES + 1);
	localparam int ICNT_W     = $clog2(MAX_IDS + 1);
	localparam int ENTRY_MAX  = (TRIE_NODES - 1 > MAX_IDS) ? TRIE_NODES - 1 : MAX_IDS;
	localparam int ENTRY_W    = $clog2(ENTRY_MAX + 1);
	localparam int MEM_DEPTH  = TRIE_NODES * (2 ** FANOUT_W);

	typedef enum logic [STATUS_W-1:0] {
		STATUS_KNOWN = 2'd0,
		STATUS_NEW   = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic                valid;
		logic [KEY_ID_W-1:0] key_id;
		status_t             status;
	} result_t;

endpackage

FILE: hw/rtl/tkim_edge_ram.sv
module tkim_edge_ram (
	input  logic                        clk,
	input  tkim_pkg::mem_req_t          req,
	output logic [tkim_pkg::ENTRY_W-1:0] rdata
);

	logic [tkim_pkg::ENTRY_W-1:0] mem [tkim_pkg::MEM_DEPTH];
	logic [tkim_pkg::ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/tkim_walk.sv
module tkim_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tkim_pkg::FANOUT_W-1:0] key_byte,
	input  logic                          res_ready,
	output tkim_pkg::result_t             res,
	output tkim_pkg::mem_req_t            mem_req,
	input  logic [tkim_pkg::ENTRY_W-1:0]  mem_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t                        state_q, state_d;
	logic [tkim_pkg::ADDR_W-1:0]   clr_q, clr_d;
	logic [tkim_pkg::NODE_W-1:0]   node_q, node_d;
	logic [tkim_pkg::NCNT_W-1:0]   nodes_used_q, nodes_used_d;
	logic [tkim_pkg::ICNT_W-1:0]   ids_used_q, ids_used_d;
	logic                          failed_q, failed_d;
	logic [tkim_pkg::FANOUT_W-1:0] byte_q;
	logic                          accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		clr_d         = clr_q;
		node_d        = node_q;
		nodes_used_d  = nodes_used_q;
		ids_used_d    = ids_used_q;
		failed_d      = failed_q;
		mem_req       = '0;
		res           = '0;
		res.status    = tkim_pkg::STATUS_KNOWN;
		case (state_q)
			ST_CLEAR: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr  = clr_q;
				clr_d         = clr_q + 1'b1;
				if (clr_q == tkim_pkg::ADDR_W'(tkim_pkg::MEM_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = {node_q, key_byte};
					state_d       = ST_LOOK;
				end
			end
			ST_LOOK: begin
				mem_req.addr = {node_q, byte_q};
				if (byte_q != '0) begin
					state_d = ST_IDLE;
					if (!failed_q) begin
						if (mem_rdata != '0) begin
							node_d = mem_rdata[tkim_pkg::NODE_W-1:0];
						end else if (nodes_used_q >= tkim_pkg::NCNT_W'(tkim_pkg::TRIE_NODES)) begin
							failed_d = 1'b1;
						end else begin
							mem_req.wr_en = 1'b1;
							mem_req.wdata = tkim_pkg::ENTRY_W'(nodes_used_q);
							node_d        = nodes_used_q[tkim_pkg::NODE_W-1:0];
							nodes_used_d  = nodes_used_q + 1'b1;
						end
					end
				end else if (res_ready) begin
					state_d   = ST_IDLE;
					res.valid = 1'b1;
					node_d    = '0;
					failed_d  = 1'b0;
					if (failed_q) begin
						res.status = tkim_pkg::STATUS_FULL;
					end else if (mem_rdata != '0) begin
						res.key_id = tkim_pkg::KEY_ID_W'(mem_rdata - 1'b1);
						res.status = tkim_pkg::STATUS_KNOWN;
					end else if (ids_used_q < tkim_pkg::ICNT_W'(tkim_pkg::MAX_IDS)) begin
						mem_req.wr_en = 1'b1;
						mem_req.wdata = tkim_pkg::ENTRY_W'(ids_used_q + 1'b1);
						res.key_id    = tkim_pkg::KEY_ID_W'(ids_used_q);
						res.status    = tkim_pkg::STATUS_NEW;
						ids_used_d    = ids_used_q + 1'b1;
					end else begin
						res.status = tkim_pkg::STATUS_FULL;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			node_q       <= '0;
			nodes_used_q <= tkim_pkg::NCNT_W'(1);
			ids_used_q   <= '0;
			failed_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			node_q       <= node_d;
			nodes_used_q <= nodes_used_d;
			ids_used_q   <= ids_used_d;
			failed_q     <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= key_byte;
		end
	end

endmodule

FILE: hw/rtl/trie_key_to_id_map.sv
// byte-trie key-to-id map: keys arrive one byte per request, a zero byte ends the key and
// returns its dense id with status known (0), new (1) or full (2); each byte is a read of the
// edge memory at {node, byte}, then a step that acts on the read data (held for the end byte
// until the output can take it), so the next node address waits on the single-port memory's
// registered read; after reset all 65536 entries are cleared one per cycle with in_ready low
module trie_key_to_id_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tkim_pkg::FANOUT_W-1:0] key_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tkim_pkg::KEY_ID_W-1:0] key_id,
	output logic [tkim_pkg::STATUS_W-1:0] status
);

	tkim_pkg::mem_req_t           mem_req;
	logic [tkim_pkg::ENTRY_W-1:0] mem_rdata;
	tkim_pkg::result_t            res;
	logic                         res_ready;
	logic                         out_valid_q;
	logic [tkim_pkg::KEY_ID_W-1:0] key_id_q;
	tkim_pkg::status_t            status_q;

	assign res_ready = !out_valid_q || out_ready;

	tkim_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_byte  (key_byte),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tkim_edge_ram u_edge_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			key_id_q <= res.key_id;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign key_id    = key_id_q;
	assign status    = status_q;

endmodule
